FILE: sv/fall_detector_freefall_impact_unit_assert.svh
// Assertion macros shared by the fall detector modules.
// Expects clk and rst to be visible in the module that uses them.
`ifndef FALL_DETECTOR_FREEFALL_IMPACT_UNIT_ASSERT_SVH
`define FALL_DETECTOR_FREEFALL_IMPACT_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define FDFI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdfi: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define FDFI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdfi: next-cycle check failed");

`endif

FILE: sv/fdfi_pkg.sv
// Package for the free-fall / impact fall detector.
// Phase codes, register indexes, configuration types. No dependencies.
`default_nettype none

package fdfi_pkg;

  // Detector phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FREE  = 2'd1;
  localparam logic [1:0] PH_WATCH = 2'd2;
  localparam logic [1:0] PH_CONF  = 2'd3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FF_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMP_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd4;

  // Register reset values
  localparam logic [31:0] FF_THR_RST  = 32'd1638400;
  localparam logic [31:0] IMP_THR_RST = 32'd26214400;
  localparam logic [15:0] FF_MIN_RST  = 16'd80;
  localparam logic [15:0] WINDOW_RST  = 16'd500;
  localparam logic [31:0] HOLD_RST    = 32'd10000;

  // Depth of the queue between classifier and phase tracker
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [31:0] ff_thr;
    logic [31:0] imp_thr;
  } thr_cfg_t;

  typedef struct packed {
    logic [15:0] ff_min;
    logic [15:0] window;
    logic [31:0] hold;
  } tim_cfg_t;

  // Classification of one sample
  typedef struct packed {
    logic low_g;
    logic impact;
  } flags_t;

endpackage

`default_nettype wire

FILE: sv/fdfi_sample_if.sv
// Sample channel: valid/ready handshake carrying three axes and a timestamp.
// Stand-alone, no package needed.
`default_nettype none

interface fdfi_sample_if #(
  parameter int AW = 16,
  parameter int TW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] accel_x;
  logic signed [AW-1:0] accel_y;
  logic signed [AW-1:0] accel_z;
  logic [TW-1:0]        time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

`default_nettype wire

FILE: sv/fdfi_result_if.sv
// Result channel: valid/ready handshake carrying alert flag and phase.
// Stand-alone, no package needed.
`default_nettype none

interface fdfi_result_if;
  logic       valid;
  logic       ready;
  logic       fall_alert;
  logic [1:0] phase;

  modport source (output valid, fall_alert, phase, input ready);
  modport sink   (input valid, fall_alert, phase, output ready);
endinterface

`default_nettype wire

FILE: sv/fdfi_queue.sv
// Small flop-based FIFO between the classifier and the phase tracker.
// Uses fdfi_pkg and the shared assertion macros.
`default_nettype none
`include "fall_detector_freefall_impact_unit_assert.svh"

module fdfi_queue #(
  parameter int W     = 34,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic              q_valid,
  output logic [W-1:0]      rdata
);
  import fdfi_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          full;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  `FDFI_ASSERT_SAME(a_no_overflow, push, !full)
  `FDFI_ASSERT_SAME(a_no_underflow, pop, q_valid)
  `FDFI_ASSERT_NEXT(a_fill_up, push && !pop, count == $past(count) + CW'(1))

endmodule

`default_nettype wire

FILE: sv/fdfi_front.sv
// Classifier: squares the axes, sums them and compares with the thresholds.
// Uses fdfi_pkg and fdfi_sample_if; feeds fdfi_queue.
`default_nettype none

module fdfi_front #(
  parameter int AW    = 16,
  parameter int TW    = 32,
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  fdfi_sample_if.sink            sample,
  input  wire fdfi_pkg::thr_cfg_t thr,
  input  wire logic              pop,
  output logic                   push,
  output logic [TW+1:0]          wdata
);
  import fdfi_pkg::*;

  localparam int PW    = 2 * AW;
  localparam int SUM_W = PW + 2;
  localparam int CMP_W = (SUM_W > 32) ? SUM_W : 32;
  localparam int CRW   = $clog2(DEPTH + 1);

  logic                 acc;
  logic [CRW-1:0]       credits;
  logic signed [PW-1:0] prod_x, prod_y, prod_z;
  logic                 v1;
  logic [PW-1:0]        sq_x, sq_y, sq_z;
  logic [TW-1:0]        t1;
  logic [SUM_W-1:0]     sum;
  logic                 v2;
  flags_t               flags2;
  logic [TW-1:0]        t2;

  // credits count beats accepted but not yet popped from the queue
  assign sample.ready = (credits < CRW'(DEPTH));
  assign acc          = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + CRW'(acc) - CRW'(pop);
    end
  end

  // stage 1: squares
  assign prod_x = sample.accel_x * sample.accel_x;
  assign prod_y = sample.accel_y * sample.accel_y;
  assign prod_z = sample.accel_z * sample.accel_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      sq_x <= unsigned'(prod_x);
      sq_y <= unsigned'(prod_y);
      sq_z <= unsigned'(prod_z);
      t1   <= sample.time_ms;
    end
  end

  // stage 2: sum and threshold compares
  assign sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      flags2.low_g  <= CMP_W'(sum) < CMP_W'(thr.ff_thr);
      flags2.impact <= CMP_W'(sum) > CMP_W'(thr.imp_thr);
      t2            <= t1;
    end
  end

  assign push  = v2;
  assign wdata = {flags2, t2};

endmodule

`default_nettype wire

FILE: sv/fdfi_back.sv
// Phase tracker: runs the idle / free fall / impact watch / confirmed machine
// and holds the result beat. Uses fdfi_pkg, fdfi_result_if and the macros.
`default_nettype none
`include "fall_detector_freefall_impact_unit_assert.svh"

module fdfi_back #(
  parameter int TW = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire logic [TW+1:0]      rdata,
  input  wire fdfi_pkg::tim_cfg_t tim,
  output logic                    pop,
  fdfi_result_if.source           result
);
  import fdfi_pkg::*;

  localparam int EW = (TW > 32) ? TW : 32;

  flags_t        flags;
  logic [TW-1:0] now;
  logic [1:0]    cur_phase, cur_phase_next;
  logic [TW-1:0] entry_time, entry_time_next;
  logic [TW-1:0] diff;
  logic [EW-1:0] elapsed;
  logic          lt_min, gt_win, ge_hold;
  logic          out_valid;
  logic          out_alert;
  logic [1:0]    out_phase;

  assign flags = rdata[TW+1:TW];
  assign now   = rdata[TW-1:0];
  assign pop   = q_valid && (!out_valid || result.ready);

  // elapsed time wraps at the timestamp width
  assign diff    = now - entry_time;
  assign elapsed = EW'(diff);
  assign lt_min  = elapsed <  EW'(tim.ff_min);
  assign gt_win  = elapsed >  EW'(tim.window);
  assign ge_hold = elapsed >= EW'(tim.hold);

  // next phase
  always_comb begin
    cur_phase_next  = cur_phase;
    entry_time_next = entry_time;
    unique case (cur_phase)
      PH_IDLE: begin
        if (flags.low_g) begin
          cur_phase_next  = PH_FREE;
          entry_time_next = now;
        end
      end
      PH_FREE: begin
        if (!flags.low_g) begin
          if (lt_min) begin
            cur_phase_next = PH_IDLE;
          end else begin
            cur_phase_next  = PH_WATCH;
            entry_time_next = now;
          end
        end else if (gt_win) begin
          cur_phase_next = PH_IDLE;
        end
      end
      PH_WATCH: begin
        if (flags.impact) begin
          cur_phase_next  = PH_CONF;
          entry_time_next = now;
        end else if (gt_win) begin
          cur_phase_next = PH_IDLE;
        end
      end
      PH_CONF: begin
        if (ge_hold) begin
          cur_phase_next = PH_IDLE;
        end
      end
      default: begin
        cur_phase_next = PH_IDLE;
      end
    endcase
  end

  // detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_phase  <= PH_IDLE;
      entry_time <= '0;
    end else if (pop) begin
      cur_phase  <= cur_phase_next;
      entry_time <= entry_time_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_alert <= (cur_phase_next == PH_CONF);
      out_phase <= cur_phase_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.fall_alert = out_alert;
  assign result.phase      = out_phase;

  `FDFI_ASSERT_SAME(a_alert_match, out_valid, out_alert == (out_phase == PH_CONF))
  `FDFI_ASSERT_NEXT(a_idle_exit, pop && cur_phase == PH_IDLE,
                    cur_phase == PH_IDLE || cur_phase == PH_FREE)
  `FDFI_ASSERT_NEXT(a_conf_entry, pop && cur_phase != PH_WATCH && cur_phase != PH_CONF,
                    cur_phase != PH_CONF)

endmodule

`default_nettype wire

FILE: sv/fall_detector_freefall_impact_unit.sv
// Free-fall / impact fall detector, one result beat per sample beat.
// Path from sample accept to result valid: squares registered at accept, then the
// sum/compare register, queue write, and phase update into the output register.
// Throughput: one sample per cycle, bounded by the four-entry queue credit.
// Reset (rst, synchronous): phase idle, entry time 0, registers to defaults.
`default_nettype none

module fall_detector_freefall_impact_unit #(
  parameter int ACCEL_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  fdfi_sample_if.sink                             sample,
  fdfi_result_if.source                           result,
  input  wire logic                               cfg_we,
  input  wire logic [fdfi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fdfi_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fdfi_pkg::*;

  thr_cfg_t              thr;
  tim_cfg_t              tim;
  logic                  push;
  logic                  pop;
  logic                  q_valid;
  logic [TIME_WIDTH+1:0] wdata;
  logic [TIME_WIDTH+1:0] rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.ff_thr  <= FF_THR_RST;
      thr.imp_thr <= IMP_THR_RST;
      tim.ff_min  <= FF_MIN_RST;
      tim.window  <= WINDOW_RST;
      tim.hold    <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FF_THR:  thr.ff_thr  <= cfg_data;
        REG_IMP_THR: thr.imp_thr <= cfg_data;
        REG_FF_MIN:  tim.ff_min  <= cfg_data[15:0];
        REG_WINDOW:  tim.window  <= cfg_data[15:0];
        REG_HOLD:    tim.hold    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fdfi_front #(
    .AW    (ACCEL_WIDTH),
    .TW    (TIME_WIDTH),
    .DEPTH (QDEPTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .thr    (thr),
    .pop    (pop),
    .push   (push),
    .wdata  (wdata)
  );

  fdfi_queue #(
    .W     (TIME_WIDTH + 2),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wdata   (wdata),
    .pop     (pop),
    .q_valid (q_valid),
    .rdata   (rdata)
  );

  fdfi_back #(
    .TW (TIME_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .rdata   (rdata),
    .tim     (tim),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire
